>>> rtl/cpts_pkg.sv
`timescale 1ns / 1ps

package cpts_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    localparam int FIELD_BITS   = 16;
    localparam int REQ_BITS     = 2;
    localparam int STATUS_BITS  = 2;
    localparam int IDX_OUT_BITS = 8;
    localparam int CNT_OUT_BITS = 9;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_ADD     = 2'd0,
        REQ_CLOSEST = 2'd1,
        REQ_FORWARD = 2'd2,
        REQ_NOP     = 2'd3
    } t_req;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

endpackage

>>> rtl/cpts_ram.sv
`timescale 1ns / 1ps

module cpts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cpts_eval.sv
`timescale 1ns / 1ps

module cpts_eval #(
    parameter int CW = 16,
    parameter int AW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpts_pkg::t_tag       i_tag,
    input  logic [AW-1:0]        i_idx,
    input  logic [3*CW-1:0]      i_cur,
    input  logic [3*CW-1:0]      i_nxt,
    input  logic [3*CW-1:0]      i_pos,
    input  logic [3*CW-1:0]      i_dir,
    output cpts_pkg::t_tag       o_tag,
    output logic [AW-1:0]        o_idx,
    output logic [3*CW-1:0]      o_pt,
    output logic [2*CW+2:0]      o_dist,
    output logic                 o_neg
);

    import cpts_pkg::*;

    localparam int DW  = CW + 1;
    localparam int SQW = 2 * DW;
    localparam int DTW = DW + CW;
    localparam int PW  = 2 * CW + 3;

    logic signed [CW-1:0]  cur [3];
    logic signed [CW-1:0]  nxt [3];
    logic signed [CW-1:0]  pos [3];
    logic signed [CW-1:0]  dir [3];
    logic signed [DW-1:0]  dx  [3];
    logic signed [DW-1:0]  st  [3];
    logic signed [SQW-1:0] n_sq [3];
    logic signed [DTW-1:0] n_dp [3];

    logic signed [SQW-1:0] r_sq [3];
    logic signed [DTW-1:0] r_dp [3];
    t_tag                  r_tag1;
    logic [AW-1:0]         r_idx1;
    logic [3*CW-1:0]       r_pt1;

    logic [PW-1:0]         n_dist;
    logic signed [DTW+1:0] n_dot;

    t_tag                  r_tag2;
    logic [AW-1:0]         r_idx2;
    logic [3*CW-1:0]       r_pt2;
    logic [PW-1:0]         r_dist;
    logic                  r_neg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cur[k]  = signed'(i_cur[k*CW +: CW]);
            nxt[k]  = signed'(i_nxt[k*CW +: CW]);
            pos[k]  = signed'(i_pos[k*CW +: CW]);
            dir[k]  = signed'(i_dir[k*CW +: CW]);
            dx[k]   = DW'(cur[k]) - DW'(pos[k]);
            st[k]   = DW'(nxt[k]) - DW'(cur[k]);
            n_sq[k] = SQW'(dx[k]) * SQW'(dx[k]);
            n_dp[k] = DTW'(st[k]) * DTW'(dir[k]);
        end
    end

    always_comb begin
        n_dist = PW'($unsigned(r_sq[0])) + PW'($unsigned(r_sq[1]))
               + PW'($unsigned(r_sq[2]));
        n_dot  = (DTW+2)'(r_dp[0]) + (DTW+2)'(r_dp[1]) + (DTW+2)'(r_dp[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= n_sq[k];
            r_dp[k] <= n_dp[k];
        end
        r_idx1 <= i_idx;
        r_pt1  <= i_cur;
        r_idx2 <= r_idx1;
        r_pt2  <= r_pt1;
        r_dist <= n_dist;
        r_neg  <= n_dot[DTW+1];
    end

    assign o_tag  = r_tag2;
    assign o_idx  = r_idx2;
    assign o_pt   = r_pt2;
    assign o_dist = r_dist;
    assign o_neg  = r_neg;

endmodule

>>> rtl/closest_point_table_search.sv
// Point table with nearest-point search. An add item is taken whenever busy is
// low and its result strobes on o_valid in the very next cycle; busy does not
// rise, so adds, rejected adds, queries on an empty table and no-op items can
// follow one another every cycle. A closest or forward query on a table of n
// points reads the point memory once per point through its single read port
// and raises busy while it runs; its result strobes in the same cycle that busy
// falls. Results are shown for one cycle only and the receiver cannot stall
// them, so it must take every item on the cycle that o_valid is high.
`timescale 1ns / 1ps

module closest_point_table_search #(
    parameter int MAX_POINTS = cpts_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cpts_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cpts_pkg::REQ_BITS-1:0]       i_req_type,
    input  logic signed [cpts_pkg::FIELD_BITS-1:0] i_coord_x,
    input  logic signed [cpts_pkg::FIELD_BITS-1:0] i_coord_y,
    input  logic signed [cpts_pkg::FIELD_BITS-1:0] i_coord_z,
    input  logic signed [cpts_pkg::FIELD_BITS-1:0] i_dir_x,
    input  logic signed [cpts_pkg::FIELD_BITS-1:0] i_dir_y,
    input  logic signed [cpts_pkg::FIELD_BITS-1:0] i_dir_z,
    output logic                                o_valid,
    output logic [cpts_pkg::STATUS_BITS-1:0]    o_status,
    output logic [cpts_pkg::IDX_OUT_BITS-1:0]   o_point_index,
    output logic signed [cpts_pkg::FIELD_BITS-1:0] o_point_x,
    output logic signed [cpts_pkg::FIELD_BITS-1:0] o_point_y,
    output logic signed [cpts_pkg::FIELD_BITS-1:0] o_point_z,
    output logic [cpts_pkg::CNT_OUT_BITS-1:0]   o_point_count
);

    import cpts_pkg::*;

    localparam int CW   = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int PTW  = 3 * CW;
    localparam int PW   = 2 * CW + 3;

    t_state          r_state, n_state;
    logic            accept;
    t_req            req;
    logic            full;
    logic [PTW-1:0]  in_pt;
    logic [PTW-1:0]  in_dir;

    logic [CNTW-1:0] r_count, n_count;
    logic [PTW-1:0]  r_pos;
    logic [PTW-1:0]  r_dir;
    logic            r_fwd;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_last_addr;

    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [PTW-1:0]  ram_rdata;

    logic            r_rd_valid;
    logic            r_rd_last;
    logic [AW-1:0]   r_rd_idx;
    logic [PTW-1:0]  r_prev;
    logic [PTW-1:0]  r_p0;
    logic            r_tail;

    t_tag            cand_tag;
    logic [AW-1:0]   cand_idx;
    logic [PTW-1:0]  cand_nxt;

    t_tag            ev_tag;
    logic [AW-1:0]   ev_idx;
    logic [PTW-1:0]  ev_pt;
    logic [PW-1:0]   ev_dist;
    logic            ev_neg;
    logic            take;
    logic            finish;

    logic            r_found;
    logic [AW-1:0]   r_best_idx;
    logic [PTW-1:0]  r_best_pt;
    logic [PW-1:0]   r_best_d;

    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic [AW-1:0]   r_out_idx, n_out_idx;
    logic [PTW-1:0]  r_out_pt, n_out_pt;
    logic [CNTW-1:0] r_out_count, n_out_count;

    assign accept = start && !busy;
    assign req    = t_req'(i_req_type);
    assign full   = (r_count == CNTW'(MAX_POINTS));
    assign in_pt  = {i_coord_z[CW-1:0], i_coord_y[CW-1:0], i_coord_x[CW-1:0]};
    assign in_dir = {i_dir_z[CW-1:0], i_dir_y[CW-1:0], i_dir_x[CW-1:0]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (req == REQ_CLOSEST || req == REQ_FORWARD)
                        && r_count != '0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == r_last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy      = (r_state != S_IDLE);
        ram_we    = accept && (req == REQ_ADD) && !full;
        ram_raddr = r_addr;
    end

    cpts_ram #(
        .WIDTH (PTW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (in_pt),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cand_tag.valid = (r_rd_valid && r_rd_idx != '0) || r_tail;
        cand_tag.last  = r_tail;
        cand_idx       = r_tail ? r_rd_idx : r_rd_idx - AW'(1);
        cand_nxt       = r_tail ? r_p0 : ram_rdata;
    end

    cpts_eval #(
        .CW (CW),
        .AW (AW)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (cand_tag),
        .i_idx   (cand_idx),
        .i_cur   (r_prev),
        .i_nxt   (cand_nxt),
        .i_pos   (r_pos),
        .i_dir   (r_dir),
        .o_tag   (ev_tag),
        .o_idx   (ev_idx),
        .o_pt    (ev_pt),
        .o_dist  (ev_dist),
        .o_neg   (ev_neg)
    );

    assign take   = ev_tag.valid && !(r_fwd && ev_neg) && (!r_found || ev_dist < r_best_d);
    assign finish = (r_state == S_DRAIN) && ev_tag.valid && ev_tag.last;

    always_comb begin
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_pt     = r_out_pt;
        n_out_count  = r_out_count;
        if (accept) begin
            unique case (req)
                REQ_ADD: begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    if (full) begin
                        n_out_status = ST_FULL;
                        n_out_idx    = '0;
                        n_out_pt     = '0;
                    end else begin
                        n_out_status = ST_OK;
                        n_out_idx    = r_count[AW-1:0];
                        n_out_pt     = in_pt;
                        n_out_count  = r_count + CNTW'(1);
                        n_count      = r_count + CNTW'(1);
                    end
                end
                REQ_CLOSEST, REQ_FORWARD: begin
                    if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_EMPTY;
                        n_out_idx    = '0;
                        n_out_pt     = '0;
                        n_out_count  = '0;
                    end
                end
                REQ_NOP: begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_idx    = '0;
                    n_out_pt     = '0;
                    n_out_count  = r_count;
                end
                default: n_out_valid = 1'b0;
            endcase
        end else if (finish) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_OK;
            n_out_count  = r_count;
            if (take) begin
                n_out_idx = ev_idx;
                n_out_pt  = ev_pt;
            end else if (r_found) begin
                n_out_idx = r_best_idx;
                n_out_pt  = r_best_pt;
            end else begin
                n_out_idx = '0;
                n_out_pt  = r_p0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_tail      <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= (r_state == S_SCAN);
            r_rd_last   <= (r_state == S_SCAN) && (r_addr == r_last_addr);
            r_tail      <= r_rd_valid && r_rd_last;
            if (accept) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_pt     <= n_out_pt;
        r_out_count  <= n_out_count;
        if (accept) begin
            r_pos       <= in_pt;
            r_dir       <= in_dir;
            r_fwd       <= (req == REQ_FORWARD);
            r_addr      <= '0;
            r_last_addr <= AW'(r_count - CNTW'(1));
        end else if (r_state == S_SCAN) begin
            r_addr <= r_addr + AW'(1);
        end
        if (r_state == S_SCAN) begin
            r_rd_idx <= r_addr;
        end
        if (r_rd_valid) begin
            r_prev <= ram_rdata;
            if (r_rd_idx == '0) begin
                r_p0 <= ram_rdata;
            end
        end
        if (take) begin
            r_best_idx <= ev_idx;
            r_best_pt  <= ev_pt;
            r_best_d   <= ev_dist;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_point_index = IDX_OUT_BITS'(r_out_idx);
    assign o_point_x     = FIELD_BITS'(signed'(r_out_pt[CW-1:0]));
    assign o_point_y     = FIELD_BITS'(signed'(r_out_pt[2*CW-1:CW]));
    assign o_point_z     = FIELD_BITS'(signed'(r_out_pt[3*CW-1:2*CW]));
    assign o_point_count = CNT_OUT_BITS'(r_out_count);

endmodule

>>> rtl/cpts_check.sv
`timescale 1ns / 1ps

module cpts_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [cpts_pkg::REQ_BITS-1:0]     i_req_type,
    input logic                              o_valid,
    input logic [cpts_pkg::STATUS_BITS-1:0]  o_status,
    input logic [cpts_pkg::CNT_OUT_BITS-1:0] o_point_count
);

    import cpts_pkg::*;

    a_add_answers_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == REQ_ADD) |=> (o_valid && o_status != ST_EMPTY))
        else $error("add item gave no result in the following cycle");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result strobed while a query is in progress");

    a_query_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("query finished without a result");

    a_empty_has_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_point_count == '0))
        else $error("empty-table status with a non-zero point count");

    a_full_only_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> $past(start && !busy && i_req_type == REQ_ADD))
        else $error("table-full status not caused by an add item");

endmodule

bind closest_point_table_search cpts_check u_cpts_check (.*);
